[rtl/deq_pkg.sv]
// Shared constants, codes and ring arithmetic for the double-ended queue.
// No dependencies; every other file in rtl/ except deq_ram refers to this package.
package deq_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_LIST       = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // (base + off) mod DEPTH; the sum stays below 2*DEPTH, so one subtract.
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] pos);
      return (pos == ADDR_W'(DEPTH - 1)) ? '0 : pos + ADDR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] pos);
      return (pos == '0) ? ADDR_W'(DEPTH - 1) : pos - ADDR_W'(1);
   endfunction

endpackage

[rtl/deq_req_if.sv]
// Request channel: valid/ready handshake carrying one request word.
// Depends on deq_pkg for the data width.
interface deq_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       req_type;
   logic signed [deq_pkg::DATA_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

[rtl/deq_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
// Depends on deq_pkg for the data width.
interface deq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [deq_pkg::DATA_W-1:0] data;
   logic [1:0]                       status;
   logic                             last;

   modport source (output valid, output data, output status, output last, input ready);
   modport sink   (input valid, input data, input status, input last, output ready);
endinterface

[rtl/deq_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/double_ended_queue_core.sv]
// Top level of the double-ended queue: ring pointers, sequencer and output register.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and deq_ram.
//
//   channel   | dir | handshake           | word
//   ----------+-----+---------------------+------------------------------------
//   req_ch    | in  | valid/ready         | req_type[2:0], value[31:0] signed
//   rsp_ch    | out | valid/ready         | data[31:0] signed, status[1:0], last
//
// Pushes and full/empty reports load the output register on accept; unknown codes
// are dropped with no word; a pop passes through S_POP (the entry RAM has a registered
// read port); a listing streams one word per cycle from the RAM read port unless stalled.
// Reset clears the state, pointers, count, listing offset and response valid only; the entry RAM needs no clearing.
// A stalled response holds its word; the listing stream pauses with it, and no
// new request is taken until the current one has put out its final word.
module double_ended_queue_core (
   input  logic         clock,
   input  logic         reset,
   deq_req_if.sink      req_ch,
   deq_rsp_if.source    rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_LIST = 3'b100
   } state_type;

   state_type                        state_ff,   state_in;
   logic [deq_pkg::ADDR_W-1:0]       front_ff,   front_in;
   logic [deq_pkg::CNT_W-1:0]        count_ff,   count_in;
   logic [deq_pkg::CNT_W-1:0]        list_off_ff, list_off_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   deq_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             ram_wr_en;
   logic [deq_pkg::ADDR_W-1:0]       ram_wr_addr;
   logic [deq_pkg::DATA_W-1:0]       ram_wr_data;
   logic                             ram_rd_en;
   logic [deq_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [deq_pkg::DATA_W-1:0]       ram_rd_data;

   logic out_free;
   logic req_accept;
   logic is_full;
   logic is_empty;
   logic list_done;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign is_full    = (count_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign is_empty   = (count_ff == '0);
   assign list_done  = (list_off_ff == count_ff);

   assign req_ch.ready  = (state_ff == S_IDLE) && out_free;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.data   = rsp_data_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.last   = rsp_last_ff;

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (deq_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      list_off_in   = list_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = front_ff;
      ram_wr_data   = req_ch.value;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_ch.req_type)
                  deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (is_full) begin
                        rsp_status_in = deq_pkg::STAT_FULL;
                     end else begin
                        rsp_status_in = deq_pkg::STAT_OK;
                        ram_wr_en     = 1'b1;
                        count_in      = count_ff + deq_pkg::CNT_W'(1);
                        if (req_ch.req_type == deq_pkg::REQ_PUSH_FRONT) begin
                           front_in    = deq_pkg::ring_dec(front_ff);
                           ram_wr_addr = deq_pkg::ring_dec(front_ff);
                        end else begin
                           ram_wr_addr = deq_pkg::ring_add(front_ff, count_ff);
                        end
                     end
                  end
                  deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = deq_pkg::STAT_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        count_in  = count_ff - deq_pkg::CNT_W'(1);
                        state_in  = S_POP;
                        if (req_ch.req_type == deq_pkg::REQ_POP_FRONT) begin
                           front_in = deq_pkg::ring_inc(front_ff);
                        end else begin
                           ram_rd_addr = deq_pkg::ring_add(front_ff,
                                                           count_ff - deq_pkg::CNT_W'(1));
                        end
                     end
                  end
                  deq_pkg::REQ_LIST: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_data_in   = '0;
                        rsp_status_in = deq_pkg::STAT_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        // prime the read port with the front entry
                        ram_rd_en   = 1'b1;
                        list_off_in = deq_pkg::CNT_W'(1);
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                     // undefined request codes are dropped silently
                  end
               endcase
            end
         end
         S_POP: begin
            // output register is free: nothing was loaded on accept
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ram_rd_data;
            rsp_status_in = deq_pkg::STAT_OK;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_LIST: begin
            // RAM output holds entry list_off-1 until it moves to the output register
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ram_rd_data;
               rsp_status_in = deq_pkg::STAT_OK;
               rsp_last_in   = list_done;
               if (list_done) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = deq_pkg::ring_add(front_ff, list_off_ff);
                  list_off_in = list_off_ff + deq_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         list_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         list_off_ff  <= list_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
      else $error("entry count above capacity");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |=> rsp_valid_ff && rsp_last_ff
                            && rsp_status_ff == deq_pkg::STAT_OK)
      else $error("pop did not produce its word");

   a_list_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST && !out_free |=> state_ff == S_LIST && $stable(list_off_ff))
      else $error("listing advanced under a stalled response");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_full
      && (req_ch.req_type == deq_pkg::REQ_PUSH_FRONT
          || req_ch.req_type == deq_pkg::REQ_PUSH_BACK)
      |=> count_ff == $past(count_ff) + deq_pkg::CNT_W'(1))
      else $error("push did not bump the entry count");

endmodule

[bench/double_ended_queue_core_tb.sv]
// Self-checking bench for double_ended_queue_core: directed table, then push/pop bursts.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and the core itself; nothing else.
module double_ended_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 190;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int SETTLE_WAIT  = 2 * deq_pkg::DEPTH + 8;

   // codes the core must ignore
   localparam logic [2:0] REQ_BAD_LO  = 3'd5;
   localparam logic [2:0] REQ_BAD_MID = 3'd6;
   localparam logic [2:0] REQ_BAD_HI  = 3'd7;

   typedef struct packed {
      logic signed [deq_pkg::DATA_W-1:0] data;
      deq_pkg::status_type               status;
      logic                              last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ROW_MODEL,   // expectation comes from the queue model
      ROW_ONE,     // single typed-in word
      ROW_NONE     // no word at all
   } row_kind_type;

   typedef struct packed {
      logic [2:0]                        code;
      logic signed [deq_pkg::DATA_W-1:0] value;
      row_kind_type                      kind;
      rsp_word_type                      word;
   } stim_row_type;

   localparam int N_ROWS = 24;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{deq_pkg::REQ_POP_FRONT,  32'sd0,         ROW_ONE,   '{32'sd0, deq_pkg::STAT_EMPTY, 1'b1}},
      '{deq_pkg::REQ_POP_BACK,   32'sd0,         ROW_ONE,   '{32'sd0, deq_pkg::STAT_EMPTY, 1'b1}},
      '{deq_pkg::REQ_LIST,       32'sd0,         ROW_ONE,   '{32'sd0, deq_pkg::STAT_EMPTY, 1'b1}},
      '{REQ_BAD_LO,              32'sh0000_1234, ROW_NONE,  '0},
      '{REQ_BAD_MID,             32'sh7fff_ffff, ROW_NONE,  '0},
      '{REQ_BAD_HI,              32'sh8000_0000, ROW_NONE,  '0},
      '{deq_pkg::REQ_PUSH_FRONT, 32'sh7fff_ffff, ROW_ONE,   '{32'sd0, deq_pkg::STAT_OK, 1'b1}},
      '{deq_pkg::REQ_PUSH_BACK,  32'sh8000_0000, ROW_ONE,   '{32'sd0, deq_pkg::STAT_OK, 1'b1}},
      '{deq_pkg::REQ_PUSH_FRONT, -32'sd1,        ROW_ONE,   '{32'sd0, deq_pkg::STAT_OK, 1'b1}},
      '{deq_pkg::REQ_PUSH_BACK,  32'sd0,         ROW_ONE,   '{32'sd0, deq_pkg::STAT_OK, 1'b1}},
      '{deq_pkg::REQ_LIST,       32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_FRONT,  32'sh5555_5555, ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_BACK,   32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_BACK,   32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_FRONT,  32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_FRONT,  32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_PUSH_BACK,  32'sh5a5a_5a5a, ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_FRONT,  -32'sd1,        ROW_MODEL, '0},
      '{deq_pkg::REQ_LIST,       32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_PUSH_FRONT, 32'sd1,         ROW_MODEL, '0},
      '{deq_pkg::REQ_PUSH_FRONT, 32'sha5a5_a5a5, ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_BACK,   32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_LIST,       32'sd0,         ROW_MODEL, '0},
      '{deq_pkg::REQ_POP_BACK,   32'sd0,         ROW_MODEL, '0}
   };

   logic clock;
   logic reset;

   deq_req_if req_ch ();
   deq_rsp_if rsp_ch ();

   double_ended_queue_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // queue model state
   logic signed [deq_pkg::DATA_W-1:0] ring_words [deq_pkg::DEPTH];
   int unsigned                       head_pos;
   int unsigned                       fill_level;

   rsp_word_type expected_words [$];
   int           fail_count;
   int           items_sent;
   int           idle_phase;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned slot_of(input int unsigned offset);
      return (head_pos + offset) % deq_pkg::DEPTH;
   endfunction

   function automatic void note(input bit keep, input rsp_word_type w);
      if (keep) begin
         expected_words.push_back(w);
      end
   endfunction

   // Advances the model by one request; its words are queued only when keep is set.
   function automatic void apply_request(input logic [2:0] code,
                                         input logic signed [deq_pkg::DATA_W-1:0] v,
                                         input bit keep);
      case (code)
         deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
            if (fill_level >= deq_pkg::DEPTH) begin
               note(keep, '{32'sd0, deq_pkg::STAT_FULL, 1'b1});
            end else begin
               if (code == deq_pkg::REQ_PUSH_FRONT) begin
                  head_pos = (head_pos + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                  ring_words[head_pos] = v;
               end else begin
                  ring_words[slot_of(fill_level)] = v;
               end
               fill_level++;
               note(keep, '{32'sd0, deq_pkg::STAT_OK, 1'b1});
            end
         end
         deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
            if (fill_level == 0) begin
               note(keep, '{32'sd0, deq_pkg::STAT_EMPTY, 1'b1});
            end else if (code == deq_pkg::REQ_POP_FRONT) begin
               note(keep, '{ring_words[head_pos], deq_pkg::STAT_OK, 1'b1});
               head_pos = slot_of(1);
               fill_level--;
            end else begin
               note(keep, '{ring_words[slot_of(fill_level - 1)], deq_pkg::STAT_OK, 1'b1});
               fill_level--;
            end
         end
         deq_pkg::REQ_LIST: begin
            if (fill_level == 0) begin
               note(keep, '{32'sd0, deq_pkg::STAT_EMPTY, 1'b1});
            end else begin
               for (int unsigned i = 0; i < fill_level; i++) begin
                  note(keep, '{ring_words[slot_of(i)], deq_pkg::STAT_OK,
                               i + 1 == fill_level});
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Drops valid and holds until every queued word has come back.
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [2:0] code,
                            input logic signed [deq_pkg::DATA_W-1:0] v,
                            input row_kind_type kind, input rsp_word_type typed);
      int phase_now;
      phase_now = items_sent * 3 / (N_ROWS + RANDOM_ITEMS);
      if (phase_now > 2) begin
         phase_now = 2;
      end
      if (phase_now != idle_phase) begin
         hold_until_drained();
         idle_phase = phase_now;
         send_idle_pct = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 56 : 0;
         recv_idle_pct = (idle_phase == 0) ? 56 : (idle_phase == 1) ? 36 : 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.value    <= v;
      do @(posedge clock); while (!req_ch.ready);
      apply_request(code, v, kind == ROW_MODEL);
      if (kind == ROW_ONE) begin
         expected_words.push_back(typed);
      end
      if (code <= deq_pkg::REQ_LIST) begin
         items_sent++;
      end
   endtask

   function automatic logic signed [deq_pkg::DATA_W-1:0] random_value();
      if ($urandom_range(7) != 0) begin
         return $urandom;
      end
      case ($urandom_range(3))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic logic [2:0] random_push();
      return $urandom_range(1) ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
   endfunction

   function automatic logic [2:0] random_pop();
      return $urandom_range(1) ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
   endfunction

   function automatic logic [2:0] random_unused();
      return 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
   endfunction

   // mostly pushes until full, then a few pushes that must report full, then a listing
   task automatic fill_burst();
      int r;
      while (fill_level < deq_pkg::DEPTH) begin
         r = $urandom_range(99);
         if (r < 6) send_word(deq_pkg::REQ_LIST, random_value(), ROW_MODEL, '0);
         else if (r < 16) send_word(random_pop(), random_value(), ROW_MODEL, '0);
         else if (r < 19) send_word(random_unused(), random_value(), ROW_MODEL, '0);
         else send_word(random_push(), random_value(), ROW_MODEL, '0);
      end
      repeat ($urandom_range(3, 1)) send_word(random_push(), random_value(), ROW_MODEL, '0);
      send_word(deq_pkg::REQ_LIST, random_value(), ROW_MODEL, '0);
   endtask

   // mostly pops until empty, then a few pops and a listing on the empty queue
   task automatic drain_burst();
      int r;
      while (fill_level > 0) begin
         r = $urandom_range(99);
         if (r < 6) send_word(deq_pkg::REQ_LIST, random_value(), ROW_MODEL, '0);
         else if (r < 16) send_word(random_push(), random_value(), ROW_MODEL, '0);
         else if (r < 19) send_word(random_unused(), random_value(), ROW_MODEL, '0);
         else send_word(random_pop(), random_value(), ROW_MODEL, '0);
      end
      repeat ($urandom_range(3, 1)) send_word(random_pop(), random_value(), ROW_MODEL, '0);
      send_word(deq_pkg::REQ_LIST, random_value(), ROW_MODEL, '0);
   endtask

   task automatic mixed_burst();
      logic [2:0] code;
      repeat ($urandom_range(40, 20)) begin
         if ($urandom_range(99) < 4) begin
            code = random_unused();
         end else begin
            code = 3'($urandom_range(deq_pkg::REQ_LIST));
         end
         send_word(code, random_value(), ROW_MODEL, '0);
      end
   endtask

   initial begin
      int burst;
      int random_start;
      head_pos      = 0;
      fill_level    = 0;
      fail_count    = 0;
      items_sent    = 0;
      idle_phase    = 0;
      send_idle_pct = 36;
      recv_idle_pct = 56;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= deq_pkg::REQ_PUSH_FRONT;
      req_ch.value    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_word(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].kind,
                   DIRECTED_ROWS[i].word);
      end
      hold_until_drained();

      burst = 0;
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         case (burst % 3)
            0:       fill_burst();
            1:       drain_burst();
            default: mixed_burst();
         endcase
         burst++;
      end

      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) begin
         @(posedge clock);
      end
      // catch stray words after the last expected one
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            $error("word with none pending: data %0d status %0d last %0d",
                   rsp_ch.data, rsp_ch.status, rsp_ch.last);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_ch.data !== want.data) begin
               $error("data: expected %0d, got %0d", want.data, rsp_ch.data);
               fail_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               fail_count++;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
